### rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Types, constants and the reflection function of the midpoint circle
// rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int CoordW  = 15;
    localparam int RadiusW = 14;
    localparam int PointW  = 16;
    localparam int DecW    = 20;

    // item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // decision constants
    localparam int DEC_INIT      = 3;
    localparam int DEC_DIAG_BIAS = 10;
    localparam int DEC_AXIS_BIAS = 6;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic        [RadiusW-1:0] radius_t;
    typedef logic signed [PointW-1:0] point_t;
    typedef logic signed [DecW-1:0]   dec_t;

    // reflection order of the eight points of one step
    typedef enum logic [2:0] {
        OCT_PX_PY,
        OCT_NX_PY,
        OCT_PX_NY,
        OCT_NX_NY,
        OCT_PY_PX,
        OCT_NY_PX,
        OCT_PY_NX,
        OCT_NY_NX
    } oct_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        coord_t ox;
        coord_t oy;
        logic   done;
    } snap_t;

    typedef struct packed {
        point_t px;
        point_t py;
    } pixel_t;

    function automatic pixel_t reflect(snap_t s, oct_t k);
        point_t cx;
        point_t cy;
        point_t ox;
        point_t oy;
        pixel_t p;
        cx = PointW'(s.cx);
        cy = PointW'(s.cy);
        ox = PointW'(s.ox);
        oy = PointW'(s.oy);
        unique case (k)
            OCT_PX_PY:
            begin
                p.px = cx + ox;
                p.py = cy + oy;
            end
            OCT_NX_PY:
            begin
                p.px = cx - ox;
                p.py = cy + oy;
            end
            OCT_PX_NY:
            begin
                p.px = cx + ox;
                p.py = cy - oy;
            end
            OCT_NX_NY:
            begin
                p.px = cx - ox;
                p.py = cy - oy;
            end
            OCT_PY_PX:
            begin
                p.px = cx + oy;
                p.py = cy + ox;
            end
            OCT_NY_PX:
            begin
                p.px = cx - oy;
                p.py = cy + ox;
            end
            OCT_PY_NX:
            begin
                p.px = cx + oy;
                p.py = cy - ox;
            end
            OCT_NY_NX:
            begin
                p.px = cx - oy;
                p.py = cy - ox;
            end
        endcase
        return p;
    endfunction

endpackage

### rtl/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr_if
// Valid/ready channels of the rasterizer: command beats in, pixel beats out.
// ----------------------------------------------------------------------------
interface mcr_cmd_if
    import mcr_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    kind;
    coord_t  center_x;
    coord_t  center_y;
    radius_t radius;

    modport source (output valid, output kind, output center_x, output center_y,
                    output radius, input ready);
    modport sink   (input valid, input kind, input center_x, input center_y,
                    input radius, output ready);
endinterface

interface mcr_pix_if
    import mcr_pkg::*;
();
    logic        valid;
    logic        ready;
    point_t      point_x;
    point_t      point_y;
    logic [2:0]  octant;
    logic        last_of_step;
    logic        circle_done;

    modport source (output valid, output point_x, output point_y, output octant,
                    output last_of_step, output circle_done, input ready);
    modport sink   (input valid, input point_x, input point_y, input octant,
                    input last_of_step, input circle_done, output ready);
endinterface

### rtl/mcr_step.sv
// ----------------------------------------------------------------------------
// mcr_step
// Circle state; a start beat sets it up, and an advance beat on an active circle
// takes one midpoint step; hands the new point to the emitter as a snapshot.
// ----------------------------------------------------------------------------
module mcr_step
    import mcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    kind,
    input  coord_t  center_x,
    input  coord_t  center_y,
    input  radius_t radius,
    output snap_t   snap,
    output logic    produce
);

    coord_t ox_reg, ox_next;
    coord_t oy_reg, oy_next;
    dec_t   dec_reg, dec_next;
    coord_t cx_reg, cx_next;
    coord_t cy_reg, cy_next;
    logic   busy_reg, busy_next;

    coord_t x_inc;
    coord_t y_dec;
    dec_t   diff;
    logic   done;

    always_comb
    begin
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        dec_next  = dec_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        busy_next = busy_reg;
        produce   = 1'b0;
        done      = 1'b0;
        x_inc     = ox_reg + coord_t'(1);
        y_dec     = oy_reg - coord_t'(1);
        diff      = dec_t'(x_inc) - dec_t'(y_dec);
        if (accept)
        begin
            if (kind == KIND_START)
            begin
                cx_next   = center_x;
                cy_next   = center_y;
                ox_next   = '0;
                oy_next   = coord_t'(radius);
                dec_next  = dec_t'(DEC_INIT) - dec_t'({radius, 1'b0});
                busy_next = 1'b1;
                produce   = 1'b1;
            end
            else if (busy_reg)
            begin
                if (oy_reg < ox_reg)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    ox_next = x_inc;
                    if (!dec_reg[DecW-1])
                    begin
                        oy_next  = y_dec;
                        dec_next = dec_reg + (diff <<< 2) + dec_t'(DEC_DIAG_BIAS);
                    end
                    else
                    begin
                        dec_next = dec_reg + (dec_t'(x_inc) <<< 2) + dec_t'(DEC_AXIS_BIAS);
                    end
                    done      = oy_next < ox_next;
                    busy_next = !done;
                    produce   = 1'b1;
                end
            end
        end
        snap.cx   = cx_next;
        snap.cy   = cy_next;
        snap.ox   = ox_next;
        snap.oy   = oy_next;
        snap.done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg   <= '0;
            oy_reg   <= '0;
            dec_reg  <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            dec_reg  <= dec_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### rtl/mcr_emit.sv
// ----------------------------------------------------------------------------
// mcr_emit
// Holds one step snapshot and sends its eight reflections, one per beat,
// through an output register.
// ----------------------------------------------------------------------------
module mcr_emit
    import mcr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  snap_t          snap_in,
    output logic           slot_free,
    mcr_pix_if.source      pix
);

    snap_t      snap_reg;
    logic       pend_reg;
    logic [2:0] idx_reg;
    logic       out_valid_reg;
    pixel_t     pixel_reg;
    logic [2:0] oct_reg;
    logic       last_reg;
    logic       done_reg;

    logic   out_free;
    logic   advance;
    logic   last_beat;
    pixel_t pixel_next;

    assign out_free   = !out_valid_reg || pix.ready;
    assign advance    = pend_reg && out_free;
    assign last_beat  = advance && (oct_t'(idx_reg) == OCT_NY_NX);
    assign slot_free  = !pend_reg || last_beat;
    assign pixel_next = reflect(snap_reg, oct_t'(idx_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pend_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (last_beat)
            begin
                pend_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 3'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_reg <= snap_in;
        end
        if (advance)
        begin
            pixel_reg <= pixel_next;
            oct_reg   <= idx_reg;
            last_reg  <= last_beat;
            done_reg  <= last_beat && snap_reg.done;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.point_x      = pixel_reg.px;
    assign pix.point_y      = pixel_reg.py;
    assign pix.octant       = oct_reg;
    assign pix.last_of_step = last_reg;
    assign pix.circle_done  = done_reg;

endmodule

### rtl/midpoint_circle_rasterizer_core.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_core
// Midpoint circle rasterizer with eight-way symmetry: start and advance
// commands in, eight reflected pixels per step out.
// ----------------------------------------------------------------------------
// A command beat loads the snapshot register; the step's first pixel then
//   moves into the output register once it is free. One pixel per beat on
//   the single output channel, eight per start or step; idle advances give none.
// A new command is taken on the cycle the eighth pixel of the last one moves
//   into the output register, so pixels flow without gaps.
// Reset: no circle active, offsets, decision and centre cleared, no pixels.
module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mcr_cmd_if.sink     cmd,
    mcr_pix_if.source   pix
);

    logic  accept;
    logic  produce;
    logic  slot_free;
    snap_t snap;

    assign cmd.ready = slot_free;
    assign accept    = cmd.valid && cmd.ready;

    mcr_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (cmd.kind),
        .center_x (cmd.center_x),
        .center_y (cmd.center_y),
        .radius   (cmd.radius),
        .snap     (snap),
        .produce  (produce)
    );

    mcr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (produce),
        .snap_in   (snap),
        .slot_free (slot_free),
        .pix       (pix)
    );

endmodule

### sim/tb_midpoint_circle_rasterizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer_core
// Self-checking bench for the midpoint circle rasterizer. Start and advance
// commands go in on the command channel with random gaps. A local model of
// the circle walk predicts the eight reflected pixels of every step, and each
// pixel beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_rasterizer_core;
    import mcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int STEP_TARGET    = 400;
    localparam int REPORT_MAX     = 20;

    typedef struct packed {
        logic    kind;
        coord_t  cx;
        coord_t  cy;
        radius_t radius;
    } circle_cmd_t;

    typedef struct {
        point_t px;
        point_t py;
        oct_t   oct;
        logic   last;
        logic   done;
    } pixel_due_t;

    logic clk;
    logic rst_n;

    mcr_cmd_if cmd_ch ();
    mcr_pix_if pix_ch ();

    midpoint_circle_rasterizer_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch)
    );

    circle_cmd_t cmds_pending[$];
    pixel_due_t  pixels_due[$];

    // model state of the circle walk
    coord_t hold_cx;
    coord_t hold_cy;
    coord_t off_x;
    coord_t off_y;
    dec_t   dec;
    logic   tracing;

    int          steps_plotted;
    int          mismatches;
    int          quiet_cycles;
    circle_cmd_t in_flight;
    logic        load_next;
    int          send_idle;
    int          send_calm;
    int          recv_stall;
    int          recv_calm;

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind  = KIND_ADVANCE;
        cmd_ch.center_x = '0;
        cmd_ch.center_y = '0;
        cmd_ch.radius   = '0;
        pix_ch.ready = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (3) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 3)
        begin
            calm = $urandom_range(16, 64);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t ns: %s", $time, what);
    endtask

    function automatic void due_pixel(point_t x, point_t y, oct_t o, logic fin);
        pixel_due_t p;
        p.px   = x;
        p.py   = y;
        p.oct  = o;
        p.last = (o == OCT_NY_NX);
        p.done = (o == OCT_NY_NX) && fin;
        pixels_due.push_back(p);
    endfunction

    task automatic queue_octants(logic fin);
        point_t cx;
        point_t cy;
        point_t ox;
        point_t oy;
        cx = point_t'(hold_cx);
        cy = point_t'(hold_cy);
        ox = point_t'(off_x);
        oy = point_t'(off_y);
        due_pixel(cx + ox, cy + oy, OCT_PX_PY, fin);
        due_pixel(cx - ox, cy + oy, OCT_NX_PY, fin);
        due_pixel(cx + ox, cy - oy, OCT_PX_NY, fin);
        due_pixel(cx - ox, cy - oy, OCT_NX_NY, fin);
        due_pixel(cx + oy, cy + ox, OCT_PY_PX, fin);
        due_pixel(cx - oy, cy + ox, OCT_NY_PX, fin);
        due_pixel(cx + oy, cy - ox, OCT_PY_NX, fin);
        due_pixel(cx - oy, cy - ox, OCT_NY_NX, fin);
        steps_plotted++;
    endtask

    task automatic plot_command(circle_cmd_t c);
        logic fin;
        fin = 1'b0;
        if (c.kind == KIND_START)
        begin
            hold_cx = c.cx;
            hold_cy = c.cy;
            off_x   = '0;
            off_y   = coord_t'({1'b0, c.radius});
            dec     = dec_t'(DEC_INIT - 2 * int'(c.radius));
            tracing = 1'b1;
            queue_octants(1'b0);
        end
        else if (tracing)
        begin
            if (off_y < off_x)
                tracing = 1'b0;
            else
            begin
                off_x = coord_t'(off_x + 1);
                if (dec >= 0)
                begin
                    off_y = coord_t'(off_y - 1);
                    dec   = dec_t'(dec + 4 * (off_x - off_y) + DEC_DIAG_BIAS);
                end
                else
                    dec = dec_t'(dec + 4 * off_x + DEC_AXIS_BIAS);
                fin = (off_y < off_x);
                if (fin)
                    tracing = 1'b0;
                queue_octants(fin);
            end
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            hold_cx       = '0;
            hold_cy       = '0;
            off_x         = '0;
            off_y         = '0;
            dec           = '0;
            tracing       = 1'b0;
            send_idle     = 0;
        end
        else
        begin
            load_next = !cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                plot_command(in_flight);
                send_idle = pick_gap(send_calm);
                load_next = 1'b1;
            end
            if (load_next)
            begin
                if (send_idle > 0 || cmds_pending.size() == 0)
                begin
                    if (send_idle > 0)
                        send_idle--;
                    cmd_ch.valid <= 1'b0;
                end
                else
                begin
                    in_flight = cmds_pending.pop_front();
                    cmd_ch.valid    <= 1'b1;
                    cmd_ch.kind     <= in_flight.kind;
                    cmd_ch.center_x <= in_flight.cx;
                    cmd_ch.center_y <= in_flight.cy;
                    cmd_ch.radius   <= in_flight.radius;
                end
            end
        end
    end

    // pixel monitor and ready stalls
    always @(posedge clk or negedge rst_n)
    begin
        pixel_due_t want;
        if (!rst_n)
        begin
            pix_ch.ready <= 1'b0;
            recv_stall    = 0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (pixels_due.size() == 0)
                    report_mismatch($sformatf("pixel beat (%0d, %0d) with nothing due",
                                              pix_ch.point_x, pix_ch.point_y));
                else
                begin
                    want = pixels_due.pop_front();
                    if (pix_ch.point_x !== want.px)
                        report_mismatch($sformatf("point_x %0d, want %0d",
                                                  pix_ch.point_x, want.px));
                    if (pix_ch.point_y !== want.py)
                        report_mismatch($sformatf("point_y %0d, want %0d",
                                                  pix_ch.point_y, want.py));
                    if (pix_ch.octant !== want.oct)
                        report_mismatch($sformatf("octant %0d, want %0d",
                                                  pix_ch.octant, want.oct));
                    if (pix_ch.last_of_step !== want.last)
                        report_mismatch($sformatf("last_of_step %b, want %b",
                                                  pix_ch.last_of_step, want.last));
                    if (pix_ch.circle_done !== want.done)
                        report_mismatch($sformatf("circle_done %b, want %b",
                                                  pix_ch.circle_done, want.done));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                pix_ch.ready <= 1'b0;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_start(coord_t cx, coord_t cy, radius_t r);
        circle_cmd_t c;
        c.kind   = KIND_START;
        c.cx     = cx;
        c.cy     = cy;
        c.radius = r;
        cmds_pending.push_back(c);
    endtask

    // advance fields other than kind are don't-care, so they carry noise
    task automatic push_advance(int n);
        circle_cmd_t c;
        repeat (n)
        begin
            c.kind   = KIND_ADVANCE;
            c.cx     = coord_t'($urandom_range(0, 32767));
            c.cy     = coord_t'($urandom_range(0, 32767));
            c.radius = radius_t'($urandom_range(0, 16383));
            cmds_pending.push_back(c);
        end
    endtask

    task automatic wait_drained();
        wait (cmds_pending.size() == 0 && !cmd_ch.valid && pixels_due.size() == 0);
    endtask

    initial
    begin
        int      r;
        int      sel;
        logic    paused;
        steps_plotted = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_calm     = 0;
        recv_calm     = 0;
        paused        = 1'b0;

        // directed: idle advance, zero radius, extremes, abandoned circles
        push_advance(1);
        push_start(coord_t'(0), coord_t'(0), radius_t'(0));
        push_advance(2);
        push_start(coord_t'(16383), coord_t'(-16384), radius_t'(1));
        push_advance(2);
        push_start(coord_t'(-16384), coord_t'(16383), radius_t'(16383));
        push_advance(3);
        push_start(coord_t'(16383), coord_t'(-16384), radius_t'(16383));
        push_advance(2);
        push_start(coord_t'(-1), coord_t'(-1), radius_t'(5));
        push_advance(6);

        wait (rst_n);
        wait_drained();
        repeat ($urandom_range(5, 40)) @(posedge clk);

        while (steps_plotted < STEP_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
            begin
                // large radius, walked a little, then dropped by the next start
                push_start(coord_t'($urandom_range(0, 32767)),
                           coord_t'($urandom_range(0, 32767)),
                           radius_t'($urandom_range(0, 16383)));
                push_advance($urandom_range(1, 12));
            end
            else
            begin
                r = $urandom_range(0, 24);
                push_start(coord_t'($urandom_range(0, 32767)),
                           coord_t'($urandom_range(0, 32767)),
                           radius_t'(r));
                if (sel < 20)
                    push_advance($urandom_range(0, r / 2));
                else
                    push_advance((r * 3) / 4 + 2 + $urandom_range(0, 1));
            end
            wait (cmds_pending.size() == 0);
            if (!paused && steps_plotted >= STEP_TARGET / 2)
            begin
                paused = 1'b1;
                wait_drained();
                repeat ($urandom_range(5, 40)) @(posedge clk);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
